/* hdl/dtlw_pkg.sv */
package dtlw_pkg;

    // arc id width and bus widths, fixed by the item layout
    localparam int ID_W          = 8;
    localparam int ID_SPACE      = 1 << ID_W;
    localparam int DATA_W        = 16;
    localparam int ARC_COUNT_DEF = 256;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        ST_PUSHED  = 2'd0,
        ST_SKIPPED = 2'd1,
        ST_POPPED  = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

    // membership mark update, at most one of set/clr per cycle
    typedef struct packed {
        logic            set;
        logic [ID_W-1:0] set_id;
        logic            clr;
        logic [ID_W-1:0] clr_id;
    } t_mark_cmd;

    // what a queue shows towards the control logic
    typedef struct packed {
        logic            empty;
        logic [ID_W-1:0] head_id;
    } t_fifo_view;

endpackage

/* hdl/dtlw_mark_table.sv */
module dtlw_mark_table
    import dtlw_pkg::*;
#(
    parameter int DEPTH = ARC_COUNT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [ID_W-1:0] i_look_id,
    output logic            o_blocked,
    input  t_mark_cmd       i_cmd
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [ID_W:0] LIMIT = (ID_W + 1)'(DEPTH);

    logic [DEPTH-1:0] r_mark;
    logic [DEPTH-1:0] n_mark;
    logic             in_range;

    // ids beyond the table have no mark and are always refused
    assign in_range  = ({1'b0, i_look_id} < LIMIT);
    assign o_blocked = !in_range || r_mark[i_look_id[AW-1:0]];

    always_comb begin
        n_mark = r_mark;
        if (i_cmd.set) begin
            n_mark[i_cmd.set_id[AW-1:0]] = 1'b1;
        end
        if (i_cmd.clr) begin
            n_mark[i_cmd.clr_id[AW-1:0]] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= '0;
        end else begin
            r_mark <= n_mark;
        end
    end

endmodule

/* hdl/dtlw_fifo.sv */
module dtlw_fifo
    import dtlw_pkg::*;
#(
    parameter int DEPTH = ARC_COUNT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [ID_W-1:0] i_data,
    input  logic            i_pop,
    output t_fifo_view      o_view
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [ID_W-1:0] mem [DEPTH];

    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic [ID_W-1:0] r_rd;
    logic            r_byp, n_byp;
    logic [ID_W-1:0] r_byp_data;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_count = r_count;
        if (i_pop) begin
            n_head  = (r_head == LAST) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
        if (i_push) begin
            n_tail  = (r_tail == LAST) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end
        // write landing on the entry read next: memory still returns old data
        n_byp = i_push && (r_tail == n_head);
    end

    // head entry prefetched every cycle so it is ready for the next pop
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_tail] <= i_data;
        end
        r_rd       <= mem[n_head];
        r_byp_data <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_byp   <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_byp   <= n_byp;
        end
    end

    assign o_view.empty   = (r_count == '0);
    assign o_view.head_id = r_byp ? r_byp_data : r_rd;

endmodule

/* hdl/dedup_two_level_worklist_unit.sv */
// deduplicating two-level arc worklist
//
// s_axis carries requests: tuser is the request kind (push or pop), tdata
// carries the arc id and its unary flag. m_axis returns one beat per request:
// tuser is the status (pushed, skipped, popped, empty), tdata the popped arc
// and whether it came from the unary queue (zero unless popped).
// a push of an id already queued, or beyond the arc count, is skipped. pops
// drain the unary queue before the other queue.
//
// one request per cycle is sustained while m_axis keeps taking results. a request
// is registered in the input register, decided there against the mark table and
// the two queue heads, and its result is then registered in the output register.
// each queue prefetches its head entry from its memory every cycle.
//
// reset clears the mark table, both queues and both stages at once; requests
// are taken from the first cycle after reset. when m_axis stalls the result
// holds, one further request is still held in the input register, and only
// then does s_axis_tready drop.
module dedup_two_level_worklist_unit
    import dtlw_pkg::*;
#(
    parameter int ARC_COUNT = ARC_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,  // [7:0] arc_id, [8] is_unary, rest zero
    input  logic              s_axis_tuser,  // [0] req_type
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,  // [7:0] popped_id, [8] popped_unary
    output logic [1:0]        m_axis_tuser   // [1:0] status
);

    // arc ids are 8 bits wide, so no more than 256 entries are ever queued
    localparam int DEPTH = (ARC_COUNT < ID_SPACE) ? ARC_COUNT : ID_SPACE;

    // input stage
    logic            r_in_vld;
    t_req            r_req;
    logic [ID_W-1:0] r_id;
    logic            r_un;

    // output stage
    logic            r_out_vld;
    t_status         r_status, n_status;
    logic [ID_W-1:0] r_pid, n_pid;
    logic            r_pun, n_pun;

    logic       adv;
    logic       work;
    logic       blocked;
    logic       push_u, push_o, pop_u, pop_o;
    t_mark_cmd  mark_cmd;
    t_fifo_view view_u, view_o;

    // output register frees when empty or taken this cycle
    assign adv           = !r_out_vld || m_axis_tready;
    assign work          = r_in_vld && adv;
    assign s_axis_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_req <= t_req'(s_axis_tuser);
            r_id  <= s_axis_tdata[ID_W-1:0];
            r_un  <= s_axis_tdata[ID_W];
        end
    end

    dtlw_mark_table #(.DEPTH(DEPTH)) u_marks (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_look_id (r_id),
        .o_blocked (blocked),
        .i_cmd     (mark_cmd)
    );

    dtlw_fifo #(.DEPTH(DEPTH)) u_unary_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_u),
        .i_data  (r_id),
        .i_pop   (pop_u),
        .o_view  (view_u)
    );

    dtlw_fifo #(.DEPTH(DEPTH)) u_other_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_o),
        .i_data  (r_id),
        .i_pop   (pop_o),
        .o_view  (view_o)
    );

    // decision: a fresh id always finds room, since each id is queued at most once
    always_comb begin
        push_u   = 1'b0;
        push_o   = 1'b0;
        pop_u    = 1'b0;
        pop_o    = 1'b0;
        n_status = ST_EMPTY;
        n_pid    = '0;
        n_pun    = 1'b0;
        unique case (r_req)
            REQ_PUSH: begin
                if (blocked) begin
                    n_status = ST_SKIPPED;
                end else begin
                    n_status = ST_PUSHED;
                    push_u   = work && r_un;
                    push_o   = work && !r_un;
                end
            end
            REQ_POP: begin
                if (!view_u.empty) begin
                    n_status = ST_POPPED;
                    n_pid    = view_u.head_id;
                    n_pun    = 1'b1;
                    pop_u    = work;
                end else if (!view_o.empty) begin
                    n_status = ST_POPPED;
                    n_pid    = view_o.head_id;
                    pop_o    = work;
                end else begin
                    n_status = ST_EMPTY;
                end
            end
            default: begin
                n_status = ST_EMPTY;
            end
        endcase
    end

    // mark set on a push, cleared for the arc leaving on a pop
    assign mark_cmd.set    = push_u || push_o;
    assign mark_cmd.set_id = r_id;
    assign mark_cmd.clr    = pop_u || pop_o;
    assign mark_cmd.clr_id = n_pid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (work) begin
            r_status <= n_status;
            r_pid    <= n_pid;
            r_pun    <= n_pun;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {{(DATA_W - ID_W - 1){1'b0}}, r_pun, r_pid};

endmodule

/* hdl/dtlw_checker.sv */
module dtlw_checker
    import dtlw_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic [1:0]        m_axis_tuser
);

    // only a successful pop carries an arc
    a_no_arc_unless_popped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_POPPED) |-> (m_axis_tdata == '0))
        else $error("arc data on a beat that is not a pop");

    // no result straight after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // with the output side empty, requests are always taken
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request refused while no result pending");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind dedup_two_level_worklist_unit dtlw_checker u_dtlw_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* test/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dtlw_pkg::*;

    localparam int ARCS           = ARC_COUNT_DEF;
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no beat on either side
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off to back up the pipe
    localparam int TAIL_CYCLES    = 20;    // settling time at the end, leave plenty of slack
    localparam int MAX_REPORTS    = 100;

    // one request beat as the worklist sees it
    typedef struct packed {
        t_req            kind;
        logic [ID_W-1:0] arc;
        logic            unary;
    } t_request;

    // one result beat
    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] arc;
        logic            unary;
    } t_outcome;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata  = '0;  // [7:0] arc_id, [8] is_unary, rest zero
    logic              s_axis_tuser  = 1'b0;  // [0] req_type
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;  // [7:0] popped_id, [8] popped_unary, rest zero
    logic [1:0]        m_axis_tuser;  // [1:0] status

    // requests waiting to be offered, results waiting to come back
    t_request req_backlog[$];
    t_outcome awaited_results[$];

    // shadow of the worklist: membership marks and the two queues
    bit              queued_mark[ARCS];
    logic [ID_W-1:0] unary_line[$];
    logic [ID_W-1:0] other_line[$];

    int  src_gap_pct   = 0;
    int  snk_stall_pct = 0;
    bit  hold_request  = 1'b0;
    bit  sink_hold     = 1'b0;
    bit  src_taken     = 1'b0;
    int  idle_cycles   = 0;
    int  mismatch_count = 0;

    dedup_two_level_worklist_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $realtime, what);
        end
    endtask

    // applies one request to the shadow worklist and gives the result it must produce
    function automatic t_outcome worklist_step(input t_request rq);
        t_outcome res;
        res.status = ST_EMPTY;
        res.arc    = '0;
        res.unary  = 1'b0;
        if (rq.kind == REQ_PUSH) begin
            // already queued (in either queue) or outside the mark table: skipped
            if (int'(rq.arc) >= ARCS || queued_mark[rq.arc]) begin
                res.status = ST_SKIPPED;
            end else if (rq.unary) begin
                if (unary_line.size() >= ARCS) begin
                    res.status = ST_SKIPPED;
                end else begin
                    queued_mark[rq.arc] = 1'b1;
                    unary_line.push_back(rq.arc);
                    res.status = ST_PUSHED;
                end
            end else begin
                if (other_line.size() >= ARCS) begin
                    res.status = ST_SKIPPED;
                end else begin
                    queued_mark[rq.arc] = 1'b1;
                    other_line.push_back(rq.arc);
                    res.status = ST_PUSHED;
                end
            end
        end else begin
            // unary queue always drains first
            if (unary_line.size() != 0) begin
                res.arc    = unary_line.pop_front();
                res.unary  = 1'b1;
                res.status = ST_POPPED;
            end else if (other_line.size() != 0) begin
                res.arc    = other_line.pop_front();
                res.status = ST_POPPED;
            end
            if (res.status == ST_POPPED && int'(res.arc) < ARCS) begin
                queued_mark[res.arc] = 1'b0;
            end
        end
        return res;
    endfunction

    // monitor: predicts on each request beat, checks each result beat, runs the watchdog
    always @(posedge i_clk) begin : monitor
        t_request seen;
        t_outcome want;
        if (!i_rst_n) begin
            src_taken   <= 1'b0;
            idle_cycles = 0;
        end else begin
            src_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                seen.kind  = t_req'(s_axis_tuser);
                seen.arc   = s_axis_tdata[ID_W-1:0];
                seen.unary = s_axis_tdata[ID_W];
                awaited_results.push_back(worklist_step(seen));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("result beat status %0d id %0d with nothing awaited",
                                              m_axis_tuser, m_axis_tdata[ID_W-1:0]));
                end else begin
                    want = awaited_results.pop_front();
                    if (m_axis_tuser !== want.status || m_axis_tdata[ID_W-1:0] !== want.arc ||
                        m_axis_tdata[ID_W] !== want.unary ||
                        m_axis_tdata[DATA_W-1:ID_W+1] !== '0) begin
                        report_mismatch($sformatf(
                            "got status %0d id %0d unary %0b pad %h, want %s id %0d unary %0b",
                            m_axis_tuser, m_axis_tdata[ID_W-1:0], m_axis_tdata[ID_W],
                            m_axis_tdata[DATA_W-1:ID_W+1], want.status.name(), want.arc,
                            want.unary));
                    end
                end
            end
            // watchdog: any beat on either side counts as progress
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
                    $display("[dedup_two_level_worklist_unit] ERROR");
                    $finish;
                end
            end
        end
    end

    // driver: a beat stays on the bus until taken, new beats are offered with random gaps
    always @(negedge i_clk) begin : request_driver
        t_request nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || src_taken) begin
            if (req_backlog.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
                nxt = req_backlog.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= nxt.kind;
                s_axis_tdata  <= DATA_W'({nxt.unary, nxt.arc});
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus the long hold-off when asked
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= !sink_hold && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // long hold-off, counted here, while the sender keeps offering
    initial begin
        wait (hold_request);
        @(negedge i_clk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        sink_hold <= 1'b0;
    end

    task automatic queue_request(input t_req kind, input logic [ID_W-1:0] arc, input logic unary);
        t_request rq;
        rq.kind  = kind;
        rq.arc   = arc;
        rq.unary = unary;
        req_backlog.push_back(rq);
    endtask

    // bursts that lean towards pushes or pops or are even, over the full id
    // range or a narrow one so that duplicates are frequent
    task automatic queue_mix(input int count);
        int left;
        int burst;
        int push_pct;
        int span;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(40, 1);
            if (burst > left) begin
                burst = left;
            end
            case ($urandom_range(2))
                0:       push_pct = 85;
                1:       push_pct = 50;
                default: push_pct = 20;
            endcase
            span = $urandom_range(1) ? 255 : 15;
            repeat (burst) begin
                if ($urandom_range(99) < push_pct) begin
                    queue_request(REQ_PUSH, ID_W'($urandom_range(span)),
                                  1'($urandom_range(1)));
                end else begin
                    // pop ignores the id and flag, keep them random
                    queue_request(REQ_POP, ID_W'($urandom), 1'($urandom_range(1)));
                end
            end
            left -= burst;
        end
    endtask

    task automatic drain_all();
        while (req_backlog.size() != 0 || s_axis_tvalid || awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input int gap_pct, input int stall_pct, input int count,
                             input bit squeeze);
        src_gap_pct   = gap_pct;
        snk_stall_pct = stall_pct;
        queue_mix(count);
        if (squeeze) begin
            hold_request = 1'b1;
        end
        drain_all();
    endtask

    initial begin : stimulus
        int order[ARCS];
        int j;
        int swap;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pops, unary before other, duplicates across queues,
        // re-push after pop, id extremes and alternating bit patterns
        queue_request(REQ_POP,  8'hff, 1'b1);
        queue_request(REQ_PUSH, 8'h00, 1'b1);
        queue_request(REQ_PUSH, 8'hff, 1'b0);
        queue_request(REQ_PUSH, 8'h00, 1'b0);
        queue_request(REQ_PUSH, 8'hff, 1'b1);
        queue_request(REQ_PUSH, 8'haa, 1'b0);
        queue_request(REQ_PUSH, 8'h55, 1'b1);
        queue_request(REQ_POP,  8'h00, 1'b0);
        queue_request(REQ_POP,  8'h00, 1'b0);
        queue_request(REQ_POP,  8'h00, 1'b0);
        queue_request(REQ_POP,  8'h00, 1'b0);
        queue_request(REQ_POP,  8'h00, 1'b0);
        queue_request(REQ_PUSH, 8'h00, 1'b0);
        queue_request(REQ_POP,  8'h55, 1'b1);
        queue_request(REQ_POP,  8'h00, 1'b0);

        // every id queued at once in shuffled order, one duplicate at full
        // occupancy, then drain one past empty
        for (int i = 0; i < ARCS; i++) begin
            order[i] = i;
        end
        for (int i = ARCS - 1; i > 0; i--) begin
            j        = $urandom_range(i);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        for (int i = 0; i < ARCS; i++) begin
            queue_request(REQ_PUSH, ID_W'(order[i]), 1'($urandom_range(1)));
        end
        queue_request(REQ_PUSH, ID_W'(order[0]), 1'($urandom_range(1)));
        for (int i = 0; i <= ARCS; i++) begin
            queue_request(REQ_POP, ID_W'($urandom), 1'($urandom_range(1)));
        end
        drain_all();

        // random phases with different idling on each side
        run_phase(63, 0,  330, 1'b0);
        run_phase(0,  63, 330, 1'b1);
        run_phase(32, 32, 330, 1'b0);
        run_phase(0,  0,  330, 1'b0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[dedup_two_level_worklist_unit] OK");
        end else begin
            $display("[dedup_two_level_worklist_unit] ERROR");
        end
        $finish;
    end

endmodule
